@@ sv/pcg_pkg.sv @@
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared constants and the output function for the PCG32 bounded generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned ST_W  = 64;
    localparam int unsigned CFG_W = 64;
    localparam int unsigned SEQ_W = 63;

    localparam logic [ST_W-1:0] LCG_MULT      = 64'd6364136223846793005;
    localparam logic [ST_W-1:0] DEFAULT_STATE = 64'h853c49e6748fea9b;
    localparam logic [ST_W-1:0] DEFAULT_INC   = 64'hda3e39cb94b95bdb;

    // Register indexes of the configuration port.
    localparam logic REG_SEED_STATE    = 1'b0;
    localparam logic REG_SEED_SEQUENCE = 1'b1;

    // XSH-RR output permutation applied to the old state.
    function automatic logic [VAL_W-1:0] pcg_output(input logic [ST_W-1:0] old);
        logic [ST_W-1:0]  mix;
        logic [VAL_W-1:0] xs;
        logic [4:0]       rot;
        mix = ((old >> 18) ^ old) >> 27;
        xs  = mix[VAL_W-1:0];
        rot = old[63:59];
        return (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));
    endfunction

endpackage

@@ sv/pcg_divider.sv @@
// ----------------------------------------------------------------------------
// pcg_divider
// Iterative 32-bit unsigned remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcg_divider
    import pcg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [VAL_W-1:0] divisor,
    output logic             done,
    output logic [VAL_W-1:0] remainder
);

    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] num_reg, num_next;
    logic [VAL_W-1:0] den_reg, den_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   diff;

    // One restoring step per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[VAL_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            cnt_next  = 6'(VAL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[VAL_W])
                rem_next = diff[VAL_W-1:0];
            else
                rem_next = trial[VAL_W-1:0];
            num_next = {num_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/pcg_front.sv @@
// ----------------------------------------------------------------------------
// pcg_front
// Input side: holds one bound and forwards it to the draw engine.
// ----------------------------------------------------------------------------
module pcg_front
    import pcg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [VAL_W-1:0] bound,
    output logic             req_valid,
    output logic [VAL_W-1:0] req_bound,
    input  logic             req_take
);

    logic             vld_reg, vld_next;
    logic [VAL_W-1:0] bnd_reg;

    // A single-entry queue between the port and the engine.
    always_comb
    begin
        vld_next = vld_reg;
        if (req_take)
            vld_next = 1'b0;
        if (push && !full)
            vld_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            bnd_reg <= bound;
    end

    assign full      = vld_reg;
    assign req_valid = vld_reg;
    assign req_bound = bnd_reg;

endmodule

@@ sv/pcg_engine.sv @@
// ----------------------------------------------------------------------------
// pcg_engine
// Back end: LCG stepping, seeding, rejection sampling and the result register.
// ----------------------------------------------------------------------------
module pcg_engine
    import pcg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic             cfg_valid_idx,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             req_valid,
    input  logic [VAL_W-1:0] req_bound,
    output logic             req_take,
    output logic             empty,
    input  logic             pop,
    output logic [VAL_W-1:0] value
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_THR    = 4'd1;
    localparam logic [3:0] S_DRAW   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_MOD    = 4'd5;
    localparam logic [3:0] S_OUT    = 4'd6;
    localparam logic [3:0] S_SEED1  = 4'd7;
    localparam logic [3:0] S_SEED2  = 4'd8;
    localparam logic [3:0] S_SEED3  = 4'd9;
    localparam logic [3:0] S_SEED4  = 4'd10;

    logic [3:0]       st_reg, st_next;
    logic [ST_W-1:0]  state_reg, state_next;
    logic [ST_W-1:0]  inc_reg, inc_next;
    logic [ST_W-1:0]  sst_reg, sst_next;
    logic [SEQ_W-1:0] sseq_reg, sseq_next;
    logic [ST_W-1:0]  prod_reg, prod_next;
    logic [VAL_W-1:0] bnd_reg, bnd_next;
    logic [VAL_W-1:0] thr_reg, thr_next;
    logic [VAL_W-1:0] r_reg, r_next;
    logic [VAL_W-1:0] out_reg, out_next;
    logic             full_reg, full_next;
    logic             div_start;
    logic [VAL_W-1:0] div_a, div_b;
    logic             div_done;
    logic [VAL_W-1:0] div_rem;
    logic [ST_W-1:0]  prod_lo, prod_mid;

    pcg_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Low 64 bits of the product from three 32x32 partials.
    assign prod_lo  = state_reg[31:0] * LCG_MULT[31:0];
    assign prod_mid = {(state_reg[63:32] * LCG_MULT[31:0]
                      + state_reg[31:0] * LCG_MULT[63:32]), 32'd0};

    // Sequencer for draws, seeding and the output slot.
    always_comb
    begin
        st_next    = st_reg;
        state_next = state_reg;
        inc_next   = inc_reg;
        sst_next   = sst_reg;
        sseq_next  = sseq_reg;
        prod_next  = prod_reg;
        bnd_next   = bnd_reg;
        thr_next   = thr_reg;
        r_next     = r_reg;
        out_next   = out_reg;
        full_next  = full_reg;
        req_take   = 1'b0;
        div_start  = 1'b0;
        div_a      = 32'd0 - bnd_reg;
        div_b      = bnd_reg;
        if (pop && full_reg)
            full_next = 1'b0;
        if (cfg_we && cfg_valid_idx)
        begin
            if (cfg_idx == REG_SEED_STATE)
                sst_next = cfg_data;
            else
                sseq_next = cfg_data[SEQ_W-1:0];
            st_next = S_SEED1;
        end
        else
        begin
            unique case (st_reg)
                S_IDLE:
                begin
                    if (req_valid && !full_reg)
                    begin
                        req_take = 1'b1;
                        bnd_next = req_bound;
                        st_next  = (req_bound == '0) ? S_DRAW : S_THR;
                        if (req_bound != '0)
                        begin
                            div_start = 1'b1;
                            div_a     = 32'd0 - req_bound;
                            div_b     = req_bound;
                        end
                    end
                end
                S_THR:
                begin
                    if (div_done)
                    begin
                        thr_next = div_rem;
                        st_next  = S_DRAW;
                    end
                end
                S_DRAW:
                begin
                    r_next    = pcg_output(state_reg);
                    prod_next = prod_lo + prod_mid;
                    st_next   = S_MUL;
                end
                S_MUL:
                begin
                    state_next = prod_reg + inc_reg;
                    st_next    = S_CHECK;
                end
                S_CHECK:
                begin
                    if (bnd_reg == '0)
                    begin
                        out_next  = r_reg;
                        st_next   = S_OUT;
                    end
                    else if (r_reg < thr_reg)
                        st_next = S_DRAW;
                    else
                    begin
                        div_start = 1'b1;
                        div_a     = r_reg;
                        st_next   = S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (div_done)
                    begin
                        out_next = div_rem;
                        st_next  = S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!full_reg)
                    begin
                        full_next = 1'b1;
                        st_next   = S_IDLE;
                    end
                end
                S_SEED1:
                begin
                    state_next = '0;
                    inc_next   = {sseq_reg, 1'b1};
                    prod_next  = '0;
                    st_next    = S_SEED2;
                end
                S_SEED2:
                begin
                    state_next = prod_reg + inc_reg + sst_reg;
                    st_next    = S_SEED3;
                end
                S_SEED3:
                begin
                    prod_next = prod_lo + prod_mid;
                    st_next   = S_SEED4;
                end
                S_SEED4:
                begin
                    state_next = prod_reg + inc_reg;
                    st_next    = S_IDLE;
                end
                default:
                    st_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            full_reg  <= 1'b0;
            state_reg <= DEFAULT_STATE;
            inc_reg   <= DEFAULT_INC;
            sst_reg   <= '0;
            sseq_reg  <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            full_reg  <= full_next;
            state_reg <= state_next;
            inc_reg   <= inc_next;
            sst_reg   <= sst_next;
            sseq_reg  <= sseq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        bnd_reg  <= bnd_next;
        thr_reg  <= thr_next;
        r_reg    <= r_next;
        out_reg  <= out_next;
    end

    assign empty = !full_reg;
    assign value = out_reg;

endmodule

@@ sv/pcg32_bounded_generator_core.sv @@
// ----------------------------------------------------------------------------
// pcg32_bounded_generator_core
// PCG32 (XSH-RR) generator: one value per request, below the bound if nonzero.
// ----------------------------------------------------------------------------
// Usage: a bound is transferred in by push while full is low. One value is
// returned per bound on value while empty is low; pop takes it. A bound of
// zero gives a raw 32-bit draw. Otherwise draws below (2^32 - bound) mod
// bound are rejected and the first accepted draw is reduced modulo bound.
// Steps: the threshold remainder from the divider, then per draw the
// S_DRAW, S_MUL and S_CHECK states, then the final remainder from the
// divider and the output step. A raw request skips both remainders; the
// shared bit-serial divider serves the two remainders.
// A single-entry queue in front lets the next bound be transferred in while
// the current one is worked on; the result register holds a value while the
// receiver stalls, and the engine waits for it to be popped.
// Reset loads the default state and increment and clears both seed
// registers. A write to either seed register reseeds via S_SEED1-S_SEED4;
// writes must go only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module pcg32_bounded_generator_core
    import pcg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             push,
    output logic             full,
    input  logic [VAL_W-1:0] bound,
    input  logic             pop,
    output logic             empty,
    output logic [VAL_W-1:0] value
);

    logic             req_valid;
    logic [VAL_W-1:0] req_bound;
    logic             req_take;

    pcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .bound     (bound),
        .req_valid (req_valid),
        .req_bound (req_bound),
        .req_take  (req_take)
    );

    pcg_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_valid_idx (1'b1),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_bound     (req_bound),
        .req_take      (req_take),
        .empty         (empty),
        .pop           (pop),
        .value         (value)
    );

    // A taken request always came from a full queue slot.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> req_valid)
        else $error("request taken from an empty slot");

    // A waiting result is held until it is popped.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value)))
        else $error("waiting result changed");

endmodule
